### hw/rtl/irc_pkg.sv
// ----------------------------------------------------------------------------
// irc_pkg: shared types and constants for the IMU repetition counter
// Sequencer states, function codes, register indexes and field widths.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int unsigned MIN_LEN_SQ = 3;
    localparam int unsigned IN_W       = 120;   // packed input word
    localparam int unsigned OUT_W      = 24;    // packed result word
    localparam int unsigned CFG_W      = 21;    // widest register
    localparam int unsigned MUL_W      = 33;    // signed multiplier operand
    localparam int unsigned PROD_W     = 2 * MUL_W;

    // function codes
    localparam logic [2:0] FUNC_UPDATE    = 3'd0;
    localparam logic [2:0] FUNC_CAP_EXT   = 3'd1;
    localparam logic [2:0] FUNC_CAP_BENT  = 3'd2;
    localparam logic [2:0] FUNC_RST_COUNT = 3'd3;
    localparam logic [2:0] FUNC_RST_CAL   = 3'd4;

    // register indexes
    localparam logic [1:0] CFG_COS_TOL  = 2'd0;
    localparam logic [1:0] CFG_COS_REL  = 2'd1;
    localparam logic [1:0] CFG_MOTION   = 2'd2;
    localparam logic [1:0] CFG_HOLD     = 2'd3;

    // phase codes
    localparam logic [1:0] PH_EXT    = 2'd0;
    localparam logic [1:0] PH_BENT   = 2'd1;
    localparam logic [1:0] PH_RETURN = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,      // squares of accel and gyro axes
        ST_LIM,     // motion_limit squared
        ST_CT,      // cos_tolerance squared
        ST_CR,      // cos_release squared
        ST_DOT,     // dot product terms
        ST_DSQ,     // dot squared
        ST_TOL,     // tolerance cone compare
        ST_REL,     // release cone compare
        ST_CAP1,    // t*t for unit vector bit test
        ST_CAP2,    // t*t*len compare
        ST_APPLY    // state update and result load
    } state_t;

endpackage

### hw/rtl/irc_mul.sv
// ----------------------------------------------------------------------------
// irc_mul: shared signed multiplier
// One 33x33 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module irc_mul (
    input  logic                                  aclk,
    input  logic signed [irc_pkg::MUL_W-1:0]      a_in,
    input  logic signed [irc_pkg::MUL_W-1:0]      b_in,
    output logic signed [irc_pkg::PROD_W-1:0]     p_out
);

    logic signed [irc_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a_in * b_in;
    end

    assign p_out = p_reg;

endmodule

### hw/rtl/imu_repetition_counter_top.sv
// ----------------------------------------------------------------------------
// imu_repetition_counter_top: exercise repetition counter from IMU samples
// Captures extended and bent reference poses as Q1.15 unit vectors and
// counts extended -> bent -> extended holds, all arithmetic on one
// shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            word
//  s_        in   s_tvalid/s_tready    func, accel xyz, gyro xyz, time_step
//  m_        out  m_tvalid/m_tready    accepted, rep_count, phase, flags
//  cfg_      in   cfg_we               cfg_index selects, cfg_wdata value
//
//  Every product goes through the one multiplier: each is issued, then its
//  registered result is used. Products per word: update, calibrated: 21;
//  update, not calibrated: 7; capture: 99 (3 if the vector is too short);
//  count/calibration resets: 0.
//  The result sits in an output register, so the next word is taken while
//  it waits; the sequencer only stalls in ST_APPLY if the old result is
//  still pending. Reset (aresetn low, synchronous) restores the register
//  defaults and clears references, count, phase, timer and locks.
//
module imu_repetition_counter_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    // func[2:0], accel_x[18:3], accel_y[34:19], accel_z[50:35],
    // gyro_x[66:51], gyro_y[82:67], gyro_z[98:83], time_step[118:99], pad
    input  logic [irc_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // accepted[0], rep_count[16:1], phase[18:17], calibrated[19],
    // still[20], near_extended[21], near_bent[22], pad
    output logic [irc_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [irc_pkg::CFG_W-1:0]   cfg_wdata
);

    irc_pkg::state_t state_reg, state_next;
    logic            ph_reg;          // 0 issue, 1 product ready
    logic [2:0]      idx_reg;
    logic            ref_reg;         // 0 extended, 1 bent
    logic [1:0]      comp_reg;
    logic [3:0]      bit_reg;

    // latched word
    logic [2:0]         func_reg;
    logic signed [15:0] samp_reg [6];
    logic [19:0]        dt_reg;
    logic [2:0]         neg_reg;

    // working registers
    logic [31:0]        len_reg, gyro_reg;
    logic [30:0]        sq_reg [3];
    logic [29:0]        lim_reg, cct_reg, ccr_reg;
    logic signed [32:0] d_reg;
    logic [63:0]        dd_reg;
    logic [1:0]         wt_reg, wr_reg;
    logic [31:0]        tt_reg;
    logic [15:0]        res_reg;
    logic signed [15:0] ucap_reg [3];

    // registers
    logic [14:0] cos_tol_reg, cos_rel_reg, motion_reg;
    logic [20:0] hold_reg;

    // architectural state
    logic signed [15:0] ext_ref_reg [3], bent_ref_reg [3];
    logic signed [15:0] ext_ref_next [3], bent_ref_next [3];
    logic        has_e_reg, has_b_reg, has_e_next, has_b_next;
    logic [1:0]  phase_reg, phase_next;
    logic [21:0] timer_reg, timer_next;
    logic        lock_e_reg, lock_b_reg, lock_e_next, lock_b_next;
    logic [15:0] count_reg, count_next;

    logic                       out_valid_reg;
    logic [irc_pkg::OUT_W-1:0]  out_data_reg;

    // multiplier
    logic signed [irc_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [irc_pkg::PROD_W-1:0] prod;

    irc_mul u_mul (
        .aclk  (aclk),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p_out (prod)
    );

    logic        accept, apply_go, cal;
    logic [31:0] len_acc;
    logic [15:0] cand, res_new;
    logic [16:0] tval;
    logic        pred;

    assign accept   = s_tvalid && s_tready;
    assign apply_go = (state_reg == irc_pkg::ST_APPLY) && (!out_valid_reg || m_tready);
    assign cal      = has_e_reg && has_b_reg;
    assign len_acc  = ((idx_reg == 3'd0) ? 32'd0 : len_reg) + prod[31:0];

    // unit vector bit test: candidate, t = 2*cand - 1
    assign cand    = res_reg | (16'd1 << bit_reg);
    assign tval    = {cand, 1'b0} - 17'd1;
    assign pred    = (cand <= 16'd32768) && (prod[63:0] <= {1'b0, sq_reg[comp_reg], 32'd0});
    assign res_new = pred ? cand : res_reg;

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            irc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tdata[2:0] == irc_pkg::FUNC_UPDATE ||
                        s_tdata[2:0] == irc_pkg::FUNC_CAP_EXT ||
                        s_tdata[2:0] == irc_pkg::FUNC_CAP_BENT)
                        state_next = irc_pkg::ST_SQ;
                    else
                        state_next = irc_pkg::ST_APPLY;
                end
            end
            irc_pkg::ST_SQ: begin
                if (ph_reg) begin
                    if (idx_reg == 3'd2 && func_reg != irc_pkg::FUNC_UPDATE)
                        state_next = (len_acc >= 32'(irc_pkg::MIN_LEN_SQ)) ?
                                     irc_pkg::ST_CAP1 : irc_pkg::ST_APPLY;
                    else if (idx_reg == 3'd5)
                        state_next = irc_pkg::ST_LIM;
                end
            end
            irc_pkg::ST_LIM: begin
                if (ph_reg) state_next = cal ? irc_pkg::ST_CT : irc_pkg::ST_APPLY;
            end
            irc_pkg::ST_CT: begin
                if (ph_reg) state_next = irc_pkg::ST_CR;
            end
            irc_pkg::ST_CR: begin
                if (ph_reg) state_next = irc_pkg::ST_DOT;
            end
            irc_pkg::ST_DOT: begin
                if (ph_reg && idx_reg == 3'd2) state_next = irc_pkg::ST_DSQ;
            end
            irc_pkg::ST_DSQ: begin
                if (ph_reg) state_next = irc_pkg::ST_TOL;
            end
            irc_pkg::ST_TOL: begin
                if (ph_reg) state_next = irc_pkg::ST_REL;
            end
            irc_pkg::ST_REL: begin
                if (ph_reg) state_next = ref_reg ? irc_pkg::ST_APPLY : irc_pkg::ST_DOT;
            end
            irc_pkg::ST_CAP1: begin
                if (ph_reg) state_next = irc_pkg::ST_CAP2;
            end
            irc_pkg::ST_CAP2: begin
                if (ph_reg)
                    state_next = (bit_reg == 4'd0 && comp_reg == 2'd2) ?
                                 irc_pkg::ST_APPLY : irc_pkg::ST_CAP1;
            end
            irc_pkg::ST_APPLY: begin
                if (apply_go) state_next = irc_pkg::ST_IDLE;
            end
            default: state_next = irc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs: ready and multiplier operands ----------------
    always_comb begin
        s_tready = (state_reg == irc_pkg::ST_IDLE);
        mul_a    = '0;
        mul_b    = '0;
        unique case (state_reg)
            irc_pkg::ST_SQ: begin
                mul_a = {{17{samp_reg[idx_reg][15]}}, samp_reg[idx_reg]};
                mul_b = mul_a;
            end
            irc_pkg::ST_LIM: begin
                mul_a = {18'd0, motion_reg};
                mul_b = mul_a;
            end
            irc_pkg::ST_CT: begin
                mul_a = {18'd0, cos_tol_reg};
                mul_b = mul_a;
            end
            irc_pkg::ST_CR: begin
                mul_a = {18'd0, cos_rel_reg};
                mul_b = mul_a;
            end
            irc_pkg::ST_DOT: begin
                mul_a = {{17{samp_reg[idx_reg][15]}}, samp_reg[idx_reg]};
                if (ref_reg)
                    mul_b = {{17{bent_ref_reg[idx_reg[1:0]][15]}}, bent_ref_reg[idx_reg[1:0]]};
                else
                    mul_b = {{17{ext_ref_reg[idx_reg[1:0]][15]}}, ext_ref_reg[idx_reg[1:0]]};
            end
            irc_pkg::ST_DSQ: begin
                mul_a = d_reg;
                mul_b = d_reg;
            end
            irc_pkg::ST_TOL: begin
                mul_a = {3'd0, cct_reg};
                mul_b = {1'b0, len_reg};
            end
            irc_pkg::ST_REL: begin
                mul_a = {3'd0, ccr_reg};
                mul_b = {1'b0, len_reg};
            end
            irc_pkg::ST_CAP1: begin
                mul_a = {16'd0, tval};
                mul_b = mul_a;
            end
            irc_pkg::ST_CAP2: begin
                mul_a = {1'b0, tt_reg};
                mul_b = {1'b0, len_reg};
            end
            irc_pkg::ST_IDLE, irc_pkg::ST_APPLY: begin
                mul_a = '0;
                mul_b = '0;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- pose / hold update ----------------
    logic        big, ne, nb, fe, fb, still, hd, le, lb, acc;
    logic [22:0] tsum;
    logic [21:0] tsat;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ext_ref_next[i]  = ext_ref_reg[i];
            bent_ref_next[i] = bent_ref_reg[i];
        end
        has_e_next  = has_e_reg;
        has_b_next  = has_b_reg;
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        lock_e_next = lock_e_reg;
        lock_b_next = lock_b_reg;
        count_next  = count_reg;
        acc         = 1'b0;

        big   = (len_reg >= 32'(irc_pkg::MIN_LEN_SQ));
        still = (func_reg == irc_pkg::FUNC_UPDATE) && (gyro_reg <= {2'b0, lim_reg});
        ne    = (func_reg == irc_pkg::FUNC_UPDATE) && cal && big && wt_reg[0];
        nb    = (func_reg == irc_pkg::FUNC_UPDATE) && cal && big && wt_reg[1];
        fe    = big ? !wr_reg[0] : (cos_rel_reg != 15'd0);
        fb    = big ? !wr_reg[1] : (cos_rel_reg != 15'd0);
        tsum  = {1'b0, timer_reg} + {3'd0, dt_reg};
        tsat  = tsum[22] ? 22'h3FFFFF : tsum[21:0];
        hd    = (tsat >= {1'b0, hold_reg});
        le    = fe ? 1'b0 : lock_e_reg;
        lb    = fb ? 1'b0 : lock_b_reg;

        unique case (func_reg)
            irc_pkg::FUNC_UPDATE: begin
                if (!cal) begin
                    timer_next = '0;
                end else begin
                    unique case (phase_reg)
                        irc_pkg::PH_EXT: begin
                            if (still && ne) begin
                                if (hd) begin
                                    timer_next  = '0;
                                    phase_next  = irc_pkg::PH_BENT;
                                    lock_e_next = 1'b1;
                                    lock_b_next = 1'b0;
                                end else begin
                                    timer_next = tsat;
                                end
                            end else begin
                                timer_next = '0;
                            end
                        end
                        irc_pkg::PH_BENT: begin
                            lock_e_next = le;
                            if (!le && still && nb) begin
                                if (hd) begin
                                    timer_next  = '0;
                                    phase_next  = irc_pkg::PH_RETURN;
                                    lock_b_next = 1'b1;
                                end else begin
                                    timer_next = tsat;
                                end
                            end else begin
                                timer_next = '0;
                            end
                        end
                        default: begin
                            lock_b_next = lb;
                            if (!lb && still && ne) begin
                                if (hd) begin
                                    timer_next  = '0;
                                    if (count_reg != 16'hFFFF) count_next = count_reg + 16'd1;
                                    phase_next  = irc_pkg::PH_BENT;
                                    lock_e_next = 1'b1;
                                    lock_b_next = 1'b0;
                                end else begin
                                    timer_next = tsat;
                                end
                            end else begin
                                timer_next = '0;
                            end
                        end
                    endcase
                end
            end
            irc_pkg::FUNC_CAP_EXT, irc_pkg::FUNC_CAP_BENT: begin
                if (big) begin
                    acc        = 1'b1;
                    phase_next = irc_pkg::PH_EXT;
                    timer_next = '0;
                    if (func_reg == irc_pkg::FUNC_CAP_EXT) begin
                        has_e_next = 1'b1;
                        for (int i = 0; i < 3; i++) ext_ref_next[i] = ucap_reg[i];
                    end else begin
                        has_b_next = 1'b1;
                        for (int i = 0; i < 3; i++) bent_ref_next[i] = ucap_reg[i];
                    end
                end
            end
            irc_pkg::FUNC_RST_COUNT, irc_pkg::FUNC_RST_CAL: begin
                count_next  = '0;
                phase_next  = irc_pkg::PH_EXT;
                timer_next  = '0;
                lock_e_next = 1'b0;
                lock_b_next = 1'b0;
                if (func_reg == irc_pkg::FUNC_RST_CAL) begin
                    has_e_next = 1'b0;
                    has_b_next = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        ext_ref_next[i]  = '0;
                        bent_ref_next[i] = '0;
                    end
                end
            end
            default: ;  // unused codes change nothing
        endcase
    end

    // ---------------- sequencer and datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= irc_pkg::ST_IDLE;
            ph_reg        <= 1'b0;
            idx_reg       <= '0;
            ref_reg       <= 1'b0;
            comp_reg      <= '0;
            bit_reg       <= 4'd15;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (apply_go) out_valid_reg <= 1'b1;

            if (accept) begin
                ph_reg   <= 1'b0;
                idx_reg  <= '0;
                ref_reg  <= 1'b0;
                comp_reg <= '0;
                bit_reg  <= 4'd15;
                res_reg  <= '0;
            end else if (state_reg != irc_pkg::ST_IDLE && state_reg != irc_pkg::ST_APPLY) begin
                ph_reg <= ~ph_reg;
                if (ph_reg) begin
                    unique case (state_reg)
                        irc_pkg::ST_SQ: begin
                            if (idx_reg == 3'd5 ||
                                (idx_reg == 3'd2 && func_reg != irc_pkg::FUNC_UPDATE))
                                idx_reg <= '0;
                            else
                                idx_reg <= idx_reg + 3'd1;
                        end
                        irc_pkg::ST_DOT: begin
                            idx_reg <= (idx_reg == 3'd2) ? 3'd0 : idx_reg + 3'd1;
                        end
                        irc_pkg::ST_REL: begin
                            ref_reg <= 1'b1;
                        end
                        irc_pkg::ST_CAP2: begin
                            if (bit_reg == 4'd0) begin
                                comp_reg <= comp_reg + 2'd1;
                                bit_reg  <= 4'd15;
                                res_reg  <= '0;
                            end else begin
                                bit_reg <= bit_reg - 4'd1;
                                res_reg <= res_new;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg    <= s_tdata[2:0];
            samp_reg[0] <= s_tdata[18:3];
            samp_reg[1] <= s_tdata[34:19];
            samp_reg[2] <= s_tdata[50:35];
            samp_reg[3] <= s_tdata[66:51];
            samp_reg[4] <= s_tdata[82:67];
            samp_reg[5] <= s_tdata[98:83];
            dt_reg      <= s_tdata[118:99];
            neg_reg     <= {s_tdata[50], s_tdata[34], s_tdata[18]};
        end
        if (ph_reg) begin
            unique case (state_reg)
                irc_pkg::ST_SQ: begin
                    if (idx_reg < 3'd3) begin
                        len_reg                <= len_acc;
                        sq_reg[idx_reg[1:0]]   <= prod[30:0];
                    end else begin
                        gyro_reg <= ((idx_reg == 3'd3) ? 32'd0 : gyro_reg) + prod[31:0];
                    end
                end
                irc_pkg::ST_LIM: lim_reg <= prod[29:0];
                irc_pkg::ST_CT:  cct_reg <= prod[29:0];
                irc_pkg::ST_CR:  ccr_reg <= prod[29:0];
                irc_pkg::ST_DOT: d_reg <= ((idx_reg == 3'd0) ? 33'sd0 : d_reg) + prod[32:0];
                irc_pkg::ST_DSQ: dd_reg <= prod[63:0];
                irc_pkg::ST_TOL: wt_reg[ref_reg] <= !d_reg[32] && (dd_reg >= prod[63:0]);
                irc_pkg::ST_REL: wr_reg[ref_reg] <= !d_reg[32] && (dd_reg >= prod[63:0]);
                irc_pkg::ST_CAP1: tt_reg <= prod[31:0];
                irc_pkg::ST_CAP2: begin
                    if (bit_reg == 4'd0) begin
                        if (neg_reg[comp_reg])
                            ucap_reg[comp_reg] <= ~res_new + 16'd1;
                        else
                            ucap_reg[comp_reg] <= res_new[15] ? 16'sh7FFF : res_new;
                    end
                end
                default: ;
            endcase
        end
        if (apply_go) begin
            out_data_reg <= {1'b0, nb, ne, still, has_e_next && has_b_next,
                             phase_next, count_next, acc};
        end
    end

    // ---------------- registers and pose state ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_tol_reg <= 15'd30792;
            cos_rel_reg <= 15'd28378;
            motion_reg  <= 15'd7860;
            hold_reg    <= 21'd300000;
            for (int i = 0; i < 3; i++) begin
                ext_ref_reg[i]  <= '0;
                bent_ref_reg[i] <= '0;
            end
            has_e_reg  <= 1'b0;
            has_b_reg  <= 1'b0;
            phase_reg  <= irc_pkg::PH_EXT;
            timer_reg  <= '0;
            lock_e_reg <= 1'b0;
            lock_b_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    irc_pkg::CFG_COS_TOL: cos_tol_reg <= cfg_wdata[14:0];
                    irc_pkg::CFG_COS_REL: cos_rel_reg <= cfg_wdata[14:0];
                    irc_pkg::CFG_MOTION:  motion_reg  <= cfg_wdata[14:0];
                    irc_pkg::CFG_HOLD:    hold_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (apply_go) begin
                for (int i = 0; i < 3; i++) begin
                    ext_ref_reg[i]  <= ext_ref_next[i];
                    bent_ref_reg[i] <= bent_ref_next[i];
                end
                has_e_reg  <= has_e_next;
                has_b_reg  <= has_b_next;
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                lock_e_reg <= lock_e_next;
                lock_b_reg <= lock_b_next;
                count_reg  <= count_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### hw/rtl/irc_checker.sv
// ----------------------------------------------------------------------------
// irc_checker: port-level checks for the repetition counter
// Watches the stream ports and the result word over time.
// ----------------------------------------------------------------------------
module irc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [irc_pkg::OUT_W-1:0]   m_tdata
);

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous word in flight");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // phase code in range
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[18:17] != irc_pkg::PH_RETURN + 2'd1)
        else $error("bad phase code");

    // no progress or pose hits without both references
    a_uncal_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[19] |->
            m_tdata[18:17] == irc_pkg::PH_EXT && !m_tdata[21] && !m_tdata[22])
        else $error("phase or near flag set while not calibrated");

endmodule

bind imu_repetition_counter_top irc_checker u_irc_checker (.*);

### bench/rep_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rep_count_checker: result predictor and scoreboard for the rep counter
// Watches the input and result channels and the register port, keeps its
// own copy of poses, locks, phase, timer and count, and compares every
// result word field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module rep_count_checker
    import irc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_W-1:0]       s_tdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [OUT_W-1:0]      m_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    output int                    fail_count,
    output int                    pending
);

    typedef struct packed {
        logic       near_b;
        logic       near_e;
        logic       still;
        logic       calibrated;
        logic [1:0] phase;
        logic [15:0] count;
        logic       accepted;
    } rep_word_t;

    typedef struct {
        longint x, y, z;
    } vec_t;

    rep_word_t  expected_q[$];
    int unsigned cos_tol, cos_rel, motion_lim, hold_us;
    vec_t       ext_pose, bent_pose;
    bit         has_ext, has_bent, ext_lock, bent_lock;
    int unsigned phase_r, timer_r, count_r;

    assign pending = expected_q.size();

    function automatic longint pose_comp(longint a, longint len_sq);
        longint mag, lo, hi, mid, t;
        mag = a < 0 ? -a : a;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            // t*t*len <= mag^2 * 2^32, done at 128 bits
            if ({64'd0, t * t} * len_sq <= ({64'd0, mag * mag} << 32)) lo = mid;
            else hi = mid - 1;
        end
        if (a < 0) return -lo;
        return lo > 32767 ? 32767 : lo;
    endfunction

    function automatic bit in_cone(vec_t a, longint len_sq, vec_t r, longint c);
        longint d;
        d = a.x * r.x + a.y * r.y + a.z * r.z;
        if (d < 0) return 0;
        return {64'd0, d} * {64'd0, d} >= {64'd0, c * c} * len_sq;
    endfunction

    function automatic bit hold_reached(int unsigned dt);
        longint t;
        t = longint'(timer_r) + dt;
        timer_r = t > 4194303 ? 4194303 : int'(t);
        if (timer_r >= hold_us) begin
            timer_r = 0;
            return 1;
        end
        return 0;
    endfunction

    task automatic clear_count();
        count_r = 0; phase_r = 0; timer_r = 0; ext_lock = 0; bent_lock = 0;
    endtask

    task automatic predict_word(logic [IN_W-1:0] w);
        logic [2:0] func;
        vec_t a, u;
        longint gx, gy, gz, len_sq, gyro_sq;
        int unsigned dt;
        bit big, far_e, far_b;
        rep_word_t r;
        func = w[2:0];
        a.x = longint'($signed(w[18:3]));
        a.y = longint'($signed(w[34:19]));
        a.z = longint'($signed(w[50:35]));
        gx = longint'($signed(w[66:51]));
        gy = longint'($signed(w[82:67]));
        gz = longint'($signed(w[98:83]));
        dt = w[118:99];
        len_sq = a.x * a.x + a.y * a.y + a.z * a.z;
        gyro_sq = gx * gx + gy * gy + gz * gz;
        r = '0;
        case (func)
            FUNC_UPDATE: begin
                r.still = gyro_sq <= longint'(motion_lim) * motion_lim;
                if (!(has_ext && has_bent)) begin
                    timer_r = 0;
                end else begin
                    big = len_sq >= MIN_LEN_SQ;
                    r.near_e = big && in_cone(a, len_sq, ext_pose, cos_tol);
                    r.near_b = big && in_cone(a, len_sq, bent_pose, cos_tol);
                    far_e = big ? !in_cone(a, len_sq, ext_pose, cos_rel) : cos_rel != 0;
                    far_b = big ? !in_cone(a, len_sq, bent_pose, cos_rel) : cos_rel != 0;
                    if (phase_r == PH_EXT) begin
                        if (r.still && r.near_e) begin
                            if (hold_reached(dt)) begin
                                phase_r = PH_BENT; ext_lock = 1; bent_lock = 0;
                            end
                        end else timer_r = 0;
                    end else if (phase_r == PH_BENT) begin
                        if (far_e) ext_lock = 0;
                        if (!ext_lock && r.still && r.near_b) begin
                            if (hold_reached(dt)) begin
                                phase_r = PH_RETURN; bent_lock = 1;
                            end
                        end else timer_r = 0;
                    end else begin
                        if (far_b) bent_lock = 0;
                        if (!bent_lock && r.still && r.near_e) begin
                            if (hold_reached(dt)) begin
                                if (count_r < 65535) count_r++;
                                phase_r = PH_BENT; ext_lock = 1; bent_lock = 0;
                            end
                        end else timer_r = 0;
                    end
                end
            end
            FUNC_CAP_EXT, FUNC_CAP_BENT: begin
                if (len_sq >= MIN_LEN_SQ) begin
                    u.x = pose_comp(a.x, len_sq);
                    u.y = pose_comp(a.y, len_sq);
                    u.z = pose_comp(a.z, len_sq);
                    if (func == FUNC_CAP_EXT) begin
                        ext_pose = u; has_ext = 1;
                    end else begin
                        bent_pose = u; has_bent = 1;
                    end
                    phase_r = PH_EXT; timer_r = 0;
                    r.accepted = 1;
                end
            end
            FUNC_RST_COUNT: clear_count();
            FUNC_RST_CAL: begin
                ext_pose = '{0, 0, 0}; bent_pose = '{0, 0, 0};
                has_ext = 0; has_bent = 0;
                clear_count();
            end
            default: ;
        endcase
        r.count = count_r[15:0];
        r.phase = phase_r[1:0];
        r.calibrated = has_ext && has_bent;
        expected_q.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        rep_word_t got, want;
        if (!aresetn) begin
            cos_tol = 30792; cos_rel = 28378; motion_lim = 7860; hold_us = 300000;
            ext_pose = '{0, 0, 0}; bent_pose = '{0, 0, 0};
            has_ext = 0; has_bent = 0;
            clear_count();
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COS_TOL: cos_tol = cfg_wdata[14:0];
                    CFG_COS_REL: cos_rel = cfg_wdata[14:0];
                    CFG_MOTION:  motion_lim = cfg_wdata[14:0];
                    CFG_HOLD:    hold_us = cfg_wdata[20:0];
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[22:0];
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", got, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.accepted != want.accepted)
                        report_mismatch("accepted", got.accepted, want.accepted);
                    if (got.count != want.count)
                        report_mismatch("rep_count", got.count, want.count);
                    if (got.phase != want.phase)
                        report_mismatch("phase", got.phase, want.phase);
                    if (got.calibrated != want.calibrated)
                        report_mismatch("calibrated", got.calibrated, want.calibrated);
                    if (got.still != want.still)
                        report_mismatch("still", got.still, want.still);
                    if (got.near_e != want.near_e)
                        report_mismatch("near_extended", got.near_e, want.near_e);
                    if (got.near_b != want.near_b)
                        report_mismatch("near_bent", got.near_b, want.near_b);
                end
            end
            if (s_tvalid && s_tready) predict_word(s_tdata);
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the IMU repetition counter
// Drives directed corner words, then random calibrate-and-exercise runs with
// noise, under random source gaps and sink stalls across several register
// settings. Checking is done by rep_count_checker.
// ----------------------------------------------------------------------------
module testbench;
    import irc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;   // idle cycles, well past a capture

    logic              aclk = 0;
    logic              aresetn = 0;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tvalid = 0;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tvalid;
    logic              m_tready = 0;
    logic              cfg_we = 0;
    logic [1:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;
    int                fail_count, pending;
    int                idle_cycles = 0;
    bit                stall_on = 1;       // sink stalls off in one register phase

    always #10 aclk = ~aclk;

    imu_repetition_counter_top i_dut (.*);

    rep_count_checker i_checker (.*);

    // sink: random stall before taking each word
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = stall_on ? $urandom_range(0, 15) : 0;
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk iff m_tvalid);
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // s_tvalid stays up after a word is taken until the next gap or idle wait
    task automatic send_word(logic [2:0] func, logic signed [15:0] ax, ay, az,
                             logic signed [15:0] gx, gy, gz, logic [19:0] dt,
                             bit gaps = 1);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {1'b0, dt, gz, gy, gx, az, ay, ax, func};
        s_tvalid <= 1;
        @(posedge aclk iff s_tready);
    endtask

    // cfg_we is dropped by the caller after the last write of a group
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // drain results, then let a running capture or update finish
    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge aclk iff pending == 0);
        repeat (250) @(posedge aclk);
    endtask

    task automatic send_random_word(bit gaps);
        send_word($urandom_range(0, 7), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, gaps);
    endtask

    // pose near a direction with jitter, gyro quiet or not
    task automatic send_pose(logic signed [15:0] px, py, pz, bit quiet, int dt_hi);
        int j;
        logic signed [15:0] gx;
        j = $urandom_range(0, 1200);
        gx = quiet ? $urandom_range(0, 3000) : $urandom;
        send_word(FUNC_UPDATE, px + $signed(j[10:0]) - 600, py + $urandom_range(0, 800) - 400,
                  pz, gx, $urandom_range(0, 2000), $urandom_range(0, 2000),
                  $urandom_range(0, dt_hi), 1);
    endtask

    // one calibrate-then-exercise run with random content
    task automatic exercise_run(int dt_hi);
        logic signed [15:0] ex, ez, bx, bz;
        ex = $urandom_range(4000, 16000); ez = $urandom_range(0, 2000);
        bx = $urandom_range(0, 2000);     bz = $urandom_range(4000, 16000);
        send_word(FUNC_CAP_EXT, ex, 0, ez, 0, 0, 0, 0, 1);
        send_word(FUNC_CAP_BENT, bx, 0, bz, 0, 0, 0, 0, 1);
        repeat ($urandom_range(2, 5)) begin
            repeat ($urandom_range(1, 6)) send_pose(ex, 0, ez, $urandom_range(0, 7) != 0, dt_hi);
            repeat ($urandom_range(1, 6)) send_pose(bx, 0, bz, $urandom_range(0, 7) != 0, dt_hi);
            if ($urandom_range(0, 9) == 0) send_random_word(1);
        end
        if ($urandom_range(0, 5) == 0) send_word(FUNC_RST_COUNT, 0, 0, 0, 0, 0, 0, 0, 1);
    endtask

    initial begin
        int sent;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, every func, short vectors, uncalibrated update
        send_word(FUNC_UPDATE, 100, 0, 0, 0, 0, 0, 50, 0);
        send_word(FUNC_CAP_EXT, 1, 1, 0, 0, 0, 0, 0, 0);         // too short
        send_word(FUNC_CAP_EXT, 32767, 0, 0, 0, 0, 0, 0, 0);     // saturates
        send_word(FUNC_CAP_BENT, -32768, -32768, -32768, 0, 0, 0, 0, 0);
        send_word(FUNC_UPDATE, 1, 0, 0, 0, 0, 0, 20'hFFFFF, 0);  // short accel
        send_word(FUNC_UPDATE, 32767, 0, 0, -32768, -32768, -32768, 20'hFFFFF, 0);
        send_word(FUNC_UPDATE, 32767, 0, 0, 0, 0, 0, 20'hFFFFF, 0);
        send_word(FUNC_UPDATE, -32768, -32768, -32768, 0, 0, 0, 20'hFFFFF, 0);
        send_word(FUNC_UPDATE, 30000, 0, 0, 10, 0, 0, 20'hFFFFF, 0);
        send_word(FUNC_UPDATE, 0, 0, 0, 0, 0, 0, 20'hFFFFF, 0);
        send_word(FUNC_UPDATE, -30000, -30000, -30000, 0, 0, 0, 20'hFFFFF, 0);
        send_word(FUNC_RST_COUNT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(3'd5, -1, -1, -1, -1, -1, -1, 20'hFFFFF, 0);
        send_word(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(3'd7, 7, 7, 7, 7, 7, 7, 7, 0);
        send_word(FUNC_RST_CAL, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_CAP_EXT, 0, -32768, 0, 0, 0, 0, 0, 0);
        send_word(FUNC_CAP_BENT, 2, 0, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // register settings: reset values, extremes, zero release, mid
        sent = 0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: ;
                1: begin
                    write_reg(CFG_COS_TOL, 16384); write_reg(CFG_COS_REL, 0);
                    write_reg(CFG_MOTION, 32750);  write_reg(CFG_HOLD, 50000);
                end
                2: begin
                    write_reg(CFG_COS_TOL, 32763); write_reg(CFG_COS_REL, 32757);
                    write_reg(CFG_MOTION, 131);    write_reg(CFG_HOLD, 2000000);
                end
                3: begin
                    write_reg(CFG_COS_TOL, 0);     write_reg(CFG_COS_REL, 15'h7FFF);
                    write_reg(CFG_MOTION, 15'h7FFF); write_reg(CFG_HOLD, 0);
                end
                4: begin
                    write_reg(CFG_COS_TOL, 28000); write_reg(CFG_COS_REL, 20000);
                    write_reg(CFG_MOTION, 5000);   write_reg(CFG_HOLD, 21'h1FFFFF);
                end
                default: begin
                    write_reg(CFG_COS_TOL, 30000); write_reg(CFG_COS_REL, 25000);
                    write_reg(CFG_MOTION, 8000);   write_reg(CFG_HOLD, 150000);
                end
            endcase
            cfg_we <= 0;
            stall_on = (ph != 3);
            repeat (9) begin
                if ($urandom_range(0, 4) == 0) send_random_word($urandom_range(0, 3) != 0);
                else exercise_run(ph == 4 ? 1048575 : 150000);
            end
            wait_idle();   // source holds until every result is back
        end

        repeat (100) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/irc_pkg.sv
hw/rtl/irc_mul.sv
hw/rtl/imu_repetition_counter_top.sv
hw/rtl/irc_checker.sv
bench/rep_count_checker.sv
bench/testbench.sv
